// ===== src/cds_pkg.sv =====
// cds_pkg: shared types, codes and the microcode table of the critically damped smoother
// no dependencies; used by critically_damped_smoother
`default_nettype none

package cds_pkg;

   localparam int REG_BITS       = 31;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DIGIT_BITS     = 16;
   localparam int PC_BITS        = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SMOOTH_TIME = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIME_STEP   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED   = 2'd2;

   localparam logic [REG_BITS-1:0] SMOOTH_TIME_RESET = 31'd9830;
   localparam logic [REG_BITS-1:0] TIME_STEP_RESET   = 31'd1092;
   localparam logic [REG_BITS-1:0] MAX_SPEED_RESET   = 31'd655360000;

   typedef enum logic [3:0] {
      OP_JCLEAN = 4'd0,
      OP_MAX    = 4'd1,
      OP_SUB    = 4'd2,
      OP_SUBS   = 4'd3,
      OP_ADDS   = 4'd4,
      OP_CLAMP  = 4'd5,
      OP_MUL    = 4'd6,
      OP_DIVW   = 4'd7,
      OP_DIVE   = 4'd8,
      OP_DONE   = 4'd9
   } op_type;

   typedef enum logic [4:0] {
      R_ST    = 5'd0,
      R_DT    = 5'd1,
      R_MS    = 5'd2,
      R_ONE   = 5'd3,
      R_KQ    = 5'd4,
      R_KC    = 5'd5,
      R_FLOOR = 5'd6,
      R_STF   = 5'd7,
      R_OMG   = 5'd8,
      R_X     = 5'd9,
      R_X2    = 5'd10,
      R_X3    = 5'd11,
      R_DEN   = 5'd12,
      R_DEC   = 5'd13,
      R_MXC   = 5'd14,
      R_CHG   = 5'd15,
      R_AIM   = 5'd16,
      R_TMP   = 5'd17,
      R_ACC   = 5'd18,
      R_POS   = 5'd19,
      R_VEL   = 5'd20,
      R_TGT   = 5'd21,
      R_NVL   = 5'd22,
      R_NPS   = 5'd23
   } reg_type;

   typedef struct packed {
      op_type               op;
      reg_type              a;
      reg_type              b;
      reg_type              dst;
      logic [PC_BITS-1:0]   jmp;
   } uop_type;

   localparam logic [PC_BITS-1:0] ITEM_PC = 5'd13;

   function automatic uop_type uop(input op_type op, input reg_type a, input reg_type b,
                                   input reg_type dst);
      uop_type u;
      u.op  = op;
      u.a   = a;
      u.b   = b;
      u.dst = dst;
      u.jmp = ITEM_PC;
      return u;
   endfunction

   // derived terms are rebuilt only after reset or a csr write
   function automatic uop_type ucode(input logic [PC_BITS-1:0] pc);
      uop_type u;
      case (pc)
         5'd0:  u = uop(OP_JCLEAN, R_ACC,  R_ACC,   R_ACC);
         5'd1:  u = uop(OP_MAX,    R_ST,   R_FLOOR, R_STF);
         5'd2:  u = uop(OP_DIVW,   R_STF,  R_STF,   R_OMG);
         5'd3:  u = uop(OP_MUL,    R_OMG,  R_DT,    R_X);
         5'd4:  u = uop(OP_MUL,    R_X,    R_X,     R_X2);
         5'd5:  u = uop(OP_MUL,    R_X2,   R_X,     R_X3);
         5'd6:  u = uop(OP_ADDS,   R_ONE,  R_X,     R_DEN);
         5'd7:  u = uop(OP_MUL,    R_KQ,   R_X2,    R_ACC);
         5'd8:  u = uop(OP_ADDS,   R_DEN,  R_ACC,   R_DEN);
         5'd9:  u = uop(OP_MUL,    R_KC,   R_X3,    R_ACC);
         5'd10: u = uop(OP_ADDS,   R_DEN,  R_ACC,   R_DEN);
         5'd11: u = uop(OP_DIVE,   R_DEN,  R_DEN,   R_DEC);
         5'd12: u = uop(OP_MUL,    R_MS,   R_STF,   R_MXC);
         5'd13: u = uop(OP_SUB,    R_POS,  R_TGT,   R_CHG);
         5'd14: u = uop(OP_CLAMP,  R_CHG,  R_MXC,   R_CHG);
         5'd15: u = uop(OP_SUBS,   R_POS,  R_CHG,   R_AIM);
         5'd16: u = uop(OP_MUL,    R_OMG,  R_CHG,   R_TMP);
         5'd17: u = uop(OP_ADDS,   R_VEL,  R_TMP,   R_TMP);
         5'd18: u = uop(OP_MUL,    R_TMP,  R_DT,    R_TMP);
         5'd19: u = uop(OP_MUL,    R_OMG,  R_TMP,   R_ACC);
         5'd20: u = uop(OP_SUBS,   R_VEL,  R_ACC,   R_ACC);
         5'd21: u = uop(OP_MUL,    R_ACC,  R_DEC,   R_NVL);
         5'd22: u = uop(OP_ADDS,   R_CHG,  R_TMP,   R_ACC);
         5'd23: u = uop(OP_MUL,    R_ACC,  R_DEC,   R_ACC);
         5'd24: u = uop(OP_ADDS,   R_AIM,  R_ACC,   R_NPS);
         default: u = uop(OP_DONE, R_ACC,  R_ACC,   R_ACC);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

// ===== src/cds_if.sv =====
// cds_if: valid/ready channels for targets in and smoothed results out
// no dependencies
`default_nettype none

interface cds_req_if #(parameter int VALUE_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] target_value;

   modport source (output valid, output target_value, input ready);
   modport sink   (input valid, input target_value, output ready);
endinterface

interface cds_rsp_if #(parameter int VALUE_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] new_position;
   logic signed [VALUE_BITS-1:0] new_velocity;
   logic                         snapped;

   modport source (output valid, output new_position, output new_velocity, output snapped,
                   input ready);
   modport sink   (input valid, input new_position, input new_velocity, input snapped,
                   output ready);
endinterface

`default_nettype wire

// ===== src/critically_damped_smoother.sv =====
// critically_damped_smoother: microcoded fixed-point spring smoother, one target in, one result out
// depends on cds_pkg (types, microcode table) and cds_if (req and rsp channels)
//
// req_ch carries one target_value per transfer; rsp_ch returns new_position, new_velocity
// and snapped for it, in order. csr_wr_en/csr_index/csr_data write smooth_time (0),
// time_step (1) and max_speed (2); write only while no item is in flight.
// A step counter walks a microcode table; one shared 16-bit-digit multiplier and a
// one-bit-per-cycle divider do the arithmetic.
// Items are taken one at a time: a new target is accepted only after the previous item's
// final step, and each item's steps include five sequential multiplies.
// After reset or any csr write the next item first rebuilds omega, decay and the
// distance limit, using the two divisions through the shared divider.
// Reset clears position, velocity and the channel control and restores csr defaults.
// The result sits in an output register; the next target is taken while it waits, and
// the sequencer holds at its final step only if the previous result is still untaken.
`default_nettype none

module critically_damped_smoother #(
   parameter int VALUE_BITS    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cds_req_if.sink                              req_ch,
   cds_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [cds_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [cds_pkg::REG_BITS-1:0]         csr_data
);

   localparam int W        = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 1;
   localparam int MW       = W - 1;
   localparam int PW       = 2 * MW;
   localparam int ND       = (MW + cds_pkg::DIGIT_BITS - 1) / cds_pkg::DIGIT_BITS;
   localparam int BPW      = ND * cds_pkg::DIGIT_BITS;
   localparam int IDX_BITS = (ND > 1) ? $clog2(ND) : 1;
   localparam int NB       = 2 * FRACTION_BITS + 2;
   localparam int QW       = (NB > W) ? NB : W;
   localparam int CNT_BITS = $clog2(NB + 1);

   localparam longint VMAX_L    = (longint'(1) << (VALUE_BITS - 1)) - 1;
   localparam longint ONE_L     = longint'(1) << FRACTION_BITS;
   localparam longint KQ_L      = ((longint'(48) << FRACTION_BITS) + 50) / 100;
   localparam longint KC_L      = ((longint'(235) << FRACTION_BITS) + 500) / 1000;
   localparam longint FLOOR_RAW = ((longint'(1) << FRACTION_BITS) + 5000) / 10000;
   localparam longint FLOOR_L   = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;

   localparam logic signed [W-1:0] VMAX_W  = W'(VMAX_L);
   localparam logic signed [W-1:0] ONE_W   = W'(ONE_L);
   localparam logic signed [W-1:0] KQ_W    = W'(KQ_L);
   localparam logic signed [W-1:0] KC_W    = W'(KC_L);
   localparam logic signed [W-1:0] FLOOR_W = W'(FLOOR_L);
   localparam logic signed [W:0]   VMAX_X  = (W + 1)'(VMAX_L);
   localparam logic signed [W:0]   VMIN_X  = (W + 1)'(-VMAX_L - 1);
   localparam logic [PW-1:0]       LIM_POS = PW'(VMAX_L);
   localparam logic [PW-1:0]       LIM_NEG = PW'(VMAX_L + 1);
   localparam logic [QW-1:0]       VMAX_Q  = QW'(VMAX_L);

   function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
      logic signed [W-1:0] r;
      if (v > VMAX_X) begin
         r = VMAX_X[W-1:0];
      end else if (v < VMIN_X) begin
         r = VMIN_X[W-1:0];
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   // control
   logic                          busy_ff, busy_in;
   logic [cds_pkg::PC_BITS-1:0]   pc_ff, pc_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                          dirty_ff, dirty_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cds_pkg::REG_BITS-1:0]  st_ff, dt_ff, ms_ff;

   // datapath registers
   logic signed [W-1:0] stf_ff, omg_ff, x_ff, x2_ff, x3_ff, den_ff, dec_ff, mxc_ff;
   logic signed [W-1:0] chg_ff, aim_ff, tmp_ff, acc_ff, nvl_ff, nps_ff;
   logic signed [W-1:0] pos_ff, vel_ff, tgt_ff;
   logic signed [W-1:0] pos_in, vel_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [MW-1:0]       rem_ff, rem_in;
   logic [NB-1:0]       quo_ff, quo_in;
   logic signed [VALUE_BITS-1:0] out_pos_ff, out_vel_ff;
   logic                out_snap_ff;

   cds_pkg::uop_type    uop;
   logic signed [W-1:0] a_val, b_val, alu_res, wr_val, mul_res, div_res;
   logic signed [W:0]   sum_x, diff_x;
   logic                wr_en, mul_step, div_step, done_fire, accept, snap;

   // multiplier
   logic signed [W-1:0]             a_abs, b_abs, qs_w;
   logic [MW-1:0]                   a_mag;
   logic [BPW-1:0]                  b_pad;
   logic [IDX_BITS-1:0]             mul_idx;
   logic [cds_pkg::DIGIT_BITS-1:0]  digit;
   logic [MW+cds_pkg::DIGIT_BITS-1:0] mul_part;
   logic [PW-1:0]                   q, lim, qs;
   logic                            mul_neg;

   // divider
   logic [MW-1:0] dvs, rem_cur;
   logic [NB-1:0] quo_cur;
   logic [MW:0]   trial, trial_sub;
   logic          nbit, ge;
   logic [QW-1:0] quo_x;

   assign uop    = cds_pkg::ucode(pc_ff);
   assign accept = req_ch.valid && !busy_ff;

   function automatic logic signed [W-1:0] pick(
      input cds_pkg::reg_type sel,
      input logic [cds_pkg::REG_BITS-1:0] st, dt, ms,
      input logic signed [W-1:0] stf, omg, x, x2, x3, den, dec, mxc,
      input logic signed [W-1:0] chg, aim, tmp, acc, pos, vel, tgt, nvl, nps);
      logic signed [W-1:0] r;
      case (sel)
         cds_pkg::R_ST:    r = W'(st);
         cds_pkg::R_DT:    r = W'(dt);
         cds_pkg::R_MS:    r = W'(ms);
         cds_pkg::R_ONE:   r = ONE_W;
         cds_pkg::R_KQ:    r = KQ_W;
         cds_pkg::R_KC:    r = KC_W;
         cds_pkg::R_FLOOR: r = FLOOR_W;
         cds_pkg::R_STF:   r = stf;
         cds_pkg::R_OMG:   r = omg;
         cds_pkg::R_X:     r = x;
         cds_pkg::R_X2:    r = x2;
         cds_pkg::R_X3:    r = x3;
         cds_pkg::R_DEN:   r = den;
         cds_pkg::R_DEC:   r = dec;
         cds_pkg::R_MXC:   r = mxc;
         cds_pkg::R_CHG:   r = chg;
         cds_pkg::R_AIM:   r = aim;
         cds_pkg::R_TMP:   r = tmp;
         cds_pkg::R_ACC:   r = acc;
         cds_pkg::R_POS:   r = pos;
         cds_pkg::R_VEL:   r = vel;
         cds_pkg::R_TGT:   r = tgt;
         cds_pkg::R_NVL:   r = nvl;
         cds_pkg::R_NPS:   r = nps;
         default:          r = '0;
      endcase
      return r;
   endfunction

   assign a_val = pick(uop.a, st_ff, dt_ff, ms_ff, stf_ff, omg_ff, x_ff, x2_ff, x3_ff, den_ff,
                       dec_ff, mxc_ff, chg_ff, aim_ff, tmp_ff, acc_ff, pos_ff, vel_ff, tgt_ff,
                       nvl_ff, nps_ff);
   assign b_val = pick(uop.b, st_ff, dt_ff, ms_ff, stf_ff, omg_ff, x_ff, x2_ff, x3_ff, den_ff,
                       dec_ff, mxc_ff, chg_ff, aim_ff, tmp_ff, acc_ff, pos_ff, vel_ff, tgt_ff,
                       nvl_ff, nps_ff);

   // combinational ALU ops
   assign sum_x  = {a_val[W-1], a_val} + {b_val[W-1], b_val};
   assign diff_x = {a_val[W-1], a_val} - {b_val[W-1], b_val};

   always_comb begin
      case (uop.op)
         cds_pkg::OP_MAX:   alu_res = (a_val < b_val) ? b_val : a_val;
         cds_pkg::OP_SUB:   alu_res = diff_x[W-1:0];
         cds_pkg::OP_SUBS:  alu_res = sat_w(diff_x);
         cds_pkg::OP_ADDS:  alu_res = sat_w(sum_x);
         cds_pkg::OP_CLAMP: begin
            if (a_val > b_val) begin
               alu_res = b_val;
            end else if (a_val < -b_val) begin
               alu_res = -b_val;
            end else begin
               alu_res = a_val;
            end
         end
         default:           alu_res = a_val;
      endcase
   end

   // shared multiplier: one 16-bit digit of |b| per cycle, then shift and saturate
   assign a_abs    = a_val[W-1] ? -a_val : a_val;
   assign b_abs    = b_val[W-1] ? -b_val : b_val;
   assign a_mag    = a_abs[MW-1:0];
   assign b_pad    = BPW'(b_abs[MW-1:0]);
   assign mul_neg  = a_val[W-1] ^ b_val[W-1];
   assign mul_idx  = cnt_ff[IDX_BITS-1:0];
   assign digit    = b_pad[cds_pkg::DIGIT_BITS*mul_idx +: cds_pkg::DIGIT_BITS];
   assign mul_part = a_mag * digit;
   assign prod_in  = ((cnt_ff == '0) ? '0 : prod_ff)
                   + (PW'(mul_part) << (cds_pkg::DIGIT_BITS * mul_idx));
   assign q        = prod_ff >> FRACTION_BITS;
   assign lim      = mul_neg ? LIM_NEG : LIM_POS;
   assign qs       = (q > lim) ? lim : q;
   assign qs_w     = qs[W-1:0];
   assign mul_res  = mul_neg ? -qs_w : qs_w;

   // shared divider: power-of-two dividend, one quotient bit per cycle
   assign dvs       = a_val[MW-1:0];
   assign rem_cur   = (cnt_ff == '0) ? '0 : rem_ff;
   assign quo_cur   = (cnt_ff == '0) ? '0 : quo_ff;
   assign nbit      = (uop.op == cds_pkg::OP_DIVW) ? (cnt_ff == CNT_BITS'(0))
                                                   : (cnt_ff == CNT_BITS'(1));
   assign trial     = {rem_cur, nbit};
   assign trial_sub = trial - {1'b0, dvs};
   assign ge        = trial >= {1'b0, dvs};
   assign rem_in    = ge ? trial_sub[MW-1:0] : trial[MW-1:0];
   assign quo_in    = {quo_cur[NB-2:0], ge};
   assign quo_x     = QW'(quo_ff);
   assign div_res   = (quo_x > VMAX_Q) ? VMAX_W : W'(quo_x);

   // overshoot snap
   assign snap   = (tgt_ff > pos_ff) == (nps_ff > tgt_ff);
   assign pos_in = snap ? tgt_ff : nps_ff;
   assign vel_in = snap ? '0 : nvl_ff;

   // sequencer
   always_comb begin
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      busy_in      = busy_ff;
      dirty_in     = dirty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      wr_en        = 1'b0;
      wr_val       = alu_res;
      mul_step     = 1'b0;
      div_step     = 1'b0;
      done_fire    = 1'b0;
      if (!busy_ff) begin
         if (req_ch.valid) begin
            busy_in = 1'b1;
            pc_in   = '0;
            cnt_in  = '0;
         end
      end else begin
         case (uop.op)
            cds_pkg::OP_JCLEAN: begin
               pc_in = dirty_ff ? pc_ff + 1'b1 : uop.jmp;
            end
            cds_pkg::OP_MUL: begin
               if (cnt_ff == CNT_BITS'(ND)) begin
                  wr_en  = 1'b1;
                  wr_val = mul_res;
                  cnt_in = '0;
                  pc_in  = pc_ff + 1'b1;
               end else begin
                  mul_step = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
            cds_pkg::OP_DIVW, cds_pkg::OP_DIVE: begin
               if (cnt_ff == CNT_BITS'(NB)) begin
                  wr_en  = 1'b1;
                  wr_val = div_res;
                  cnt_in = '0;
                  pc_in  = pc_ff + 1'b1;
               end else begin
                  div_step = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
            cds_pkg::OP_DONE: begin
               if (!(rsp_valid_ff && !rsp_ch.ready)) begin
                  done_fire    = 1'b1;
                  rsp_valid_in = 1'b1;
                  busy_in      = 1'b0;
                  dirty_in     = 1'b0;
               end
            end
            default: begin
               wr_en = 1'b1;
               pc_in = pc_ff + 1'b1;
            end
         endcase
      end
      if (csr_wr_en) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         dirty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         st_ff        <= cds_pkg::SMOOTH_TIME_RESET;
         dt_ff        <= cds_pkg::TIME_STEP_RESET;
         ms_ff        <= cds_pkg::MAX_SPEED_RESET;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done_fire) begin
            pos_ff <= pos_in;
            vel_ff <= vel_in;
         end
         if (csr_wr_en) begin
            case (csr_index)
               cds_pkg::CSR_SMOOTH_TIME: st_ff <= csr_data;
               cds_pkg::CSR_TIME_STEP:   dt_ff <= csr_data;
               cds_pkg::CSR_MAX_SPEED:   ms_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tgt_ff <= W'(req_ch.target_value);
      end
      if (mul_step) begin
         prod_ff <= prod_in;
      end
      if (div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (done_fire) begin
         out_pos_ff  <= pos_in[VALUE_BITS-1:0];
         out_vel_ff  <= vel_in[VALUE_BITS-1:0];
         out_snap_ff <= snap;
      end
      if (wr_en) begin
         case (uop.dst)
            cds_pkg::R_STF: stf_ff <= wr_val;
            cds_pkg::R_OMG: omg_ff <= wr_val;
            cds_pkg::R_X:   x_ff   <= wr_val;
            cds_pkg::R_X2:  x2_ff  <= wr_val;
            cds_pkg::R_X3:  x3_ff  <= wr_val;
            cds_pkg::R_DEN: den_ff <= wr_val;
            cds_pkg::R_DEC: dec_ff <= wr_val;
            cds_pkg::R_MXC: mxc_ff <= wr_val;
            cds_pkg::R_CHG: chg_ff <= wr_val;
            cds_pkg::R_AIM: aim_ff <= wr_val;
            cds_pkg::R_TMP: tmp_ff <= wr_val;
            cds_pkg::R_ACC: acc_ff <= wr_val;
            cds_pkg::R_NVL: nvl_ff <= wr_val;
            cds_pkg::R_NPS: nps_ff <= wr_val;
            default: ;
         endcase
      end
   end

   assign req_ch.ready        = !busy_ff;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.new_position = out_pos_ff;
   assign rsp_ch.new_velocity = out_vel_ff;
   assign rsp_ch.snapped      = out_snap_ff;

endmodule

`default_nettype wire
